@@ src/c8alu_pkg.sv @@
// ----------------------------------------------------------------------------
// c8alu_pkg
// Operation codes, flag bundle and constants shared by the 8-bit ALU files.
// ----------------------------------------------------------------------------
`default_nettype none

package c8alu_pkg;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_RLCA = 5'd10,
    OP_RRCA = 5'd11,
    OP_RLA  = 5'd12,
    OP_RRA  = 5'd13,
    OP_DAA  = 5'd14,
    OP_CPL  = 5'd15,
    OP_SCF  = 5'd16,
    OP_CCF  = 5'd17,
    OP_RLC  = 5'd18,
    OP_RRC  = 5'd19,
    OP_RL   = 5'd20,
    OP_RR   = 5'd21,
    OP_SLA  = 5'd22,
    OP_SRA  = 5'd23,
    OP_SWAP = 5'd24,
    OP_SRL  = 5'd25,
    OP_BIT  = 5'd26,
    OP_RES  = 5'd27,
    OP_SET  = 5'd28
  } op_e;

  // zero, subtract, half-carry, carry
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  localparam logic [7:0] DaaHiLimit = 8'h99;
  localparam logic [3:0] DaaLoLimit = 4'h9;

endpackage

`default_nettype wire

@@ src/c8alu_core.sv @@
// ----------------------------------------------------------------------------
// c8alu_core
// Combinational datapath: one operation on registered operands and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module c8alu_core (
  input  wire logic [4:0]       op_i,
  input  wire logic [7:0]       a_i,
  input  wire logic [7:0]       v_i,
  input  wire logic [2:0]       bit_index_i,
  input  wire c8alu_pkg::flags_t flags_i,
  output logic [7:0]            result_o,
  output logic                  writes_o,
  output c8alu_pkg::flags_t     flags_o
);
  import c8alu_pkg::*;

  op_e        op;
  logic       add_cc;
  logic       sub_cc;
  logic [8:0] add_sum;
  logic [4:0] add_half;
  logic [8:0] sub_dif;
  logic [4:0] sub_half;
  logic [7:0] inc_res;
  logic [7:0] dec_res;
  logic [7:0] sh_res;
  logic       sh_c;
  logic       corr_lo;
  logic       corr_hi;
  logic [7:0] corr;
  logic [7:0] daa_res;
  logic [7:0] mask;

  assign op = op_e'(op_i);

  assign add_cc   = (op == OP_ADC) & flags_i.c;
  assign sub_cc   = (op == OP_SBC) & flags_i.c;
  assign add_sum  = {1'b0, a_i} + {1'b0, v_i} + {8'h00, add_cc};
  assign add_half = {1'b0, a_i[3:0]} + {1'b0, v_i[3:0]} + {4'h0, add_cc};
  assign sub_dif  = {1'b0, a_i} - {1'b0, v_i} - {8'h00, sub_cc};
  assign sub_half = {1'b0, a_i[3:0]} - {1'b0, v_i[3:0]} - {4'h0, sub_cc};
  assign inc_res  = v_i + 8'd1;
  assign dec_res  = v_i - 8'd1;
  assign mask     = 8'b1 << bit_index_i;

  // decimal adjust correction, subtracted after a subtraction
  assign corr_lo = flags_i.h | (~flags_i.n & (a_i[3:0] > DaaLoLimit));
  assign corr_hi = flags_i.c | (~flags_i.n & (a_i > DaaHiLimit));
  assign corr    = {1'b0, corr_hi, corr_hi, 2'b00, corr_lo, corr_lo, 1'b0};
  assign daa_res = flags_i.n ? (a_i - corr) : (a_i + corr);

  // prefixed shifts and rotates on the operand
  always_comb begin
    sh_res = v_i;
    sh_c   = 1'b0;
    unique case (op)
      OP_RLC: begin
        sh_res = {v_i[6:0], v_i[7]};
        sh_c   = v_i[7];
      end
      OP_RRC: begin
        sh_res = {v_i[0], v_i[7:1]};
        sh_c   = v_i[0];
      end
      OP_RL: begin
        sh_res = {v_i[6:0], flags_i.c};
        sh_c   = v_i[7];
      end
      OP_RR: begin
        sh_res = {flags_i.c, v_i[7:1]};
        sh_c   = v_i[0];
      end
      OP_SLA: begin
        sh_res = {v_i[6:0], 1'b0};
        sh_c   = v_i[7];
      end
      OP_SRA: begin
        sh_res = {v_i[7], v_i[7:1]};
        sh_c   = v_i[0];
      end
      OP_SWAP: begin
        sh_res = {v_i[3:0], v_i[7:4]};
        sh_c   = 1'b0;
      end
      OP_SRL: begin
        sh_res = {1'b0, v_i[7:1]};
        sh_c   = v_i[0];
      end
      default: begin
        sh_res = v_i;
        sh_c   = 1'b0;
      end
    endcase
  end

  always_comb begin
    result_o = a_i;
    writes_o = 1'b0;
    flags_o  = flags_i;
    unique case (op)
      OP_ADD, OP_ADC: begin
        result_o = add_sum[7:0];
        writes_o = 1'b1;
        flags_o  = '{z: (add_sum[7:0] == 8'h00), n: 1'b0, h: add_half[4], c: add_sum[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        result_o = sub_dif[7:0];
        writes_o = (op != OP_CP);
        flags_o  = '{z: (sub_dif[7:0] == 8'h00), n: 1'b1, h: sub_half[4], c: sub_dif[8]};
      end
      OP_AND: begin
        result_o = a_i & v_i;
        writes_o = 1'b1;
        flags_o  = '{z: ((a_i & v_i) == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      OP_XOR: begin
        result_o = a_i ^ v_i;
        writes_o = 1'b1;
        flags_o  = '{z: ((a_i ^ v_i) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_OR: begin
        result_o = a_i | v_i;
        writes_o = 1'b1;
        flags_o  = '{z: ((a_i | v_i) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_INC: begin
        result_o = inc_res;
        writes_o = 1'b1;
        flags_o  = '{z: (inc_res == 8'h00), n: 1'b0, h: (v_i[3:0] == 4'hf), c: flags_i.c};
      end
      OP_DEC: begin
        result_o = dec_res;
        writes_o = 1'b1;
        flags_o  = '{z: (dec_res == 8'h00), n: 1'b1, h: (v_i[3:0] == 4'h0), c: flags_i.c};
      end
      OP_RLCA: begin
        result_o = {a_i[6:0], a_i[7]};
        writes_o = 1'b1;
        flags_o  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a_i[7]};
      end
      OP_RRCA: begin
        result_o = {a_i[0], a_i[7:1]};
        writes_o = 1'b1;
        flags_o  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a_i[0]};
      end
      OP_RLA: begin
        result_o = {a_i[6:0], flags_i.c};
        writes_o = 1'b1;
        flags_o  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a_i[7]};
      end
      OP_RRA: begin
        result_o = {flags_i.c, a_i[7:1]};
        writes_o = 1'b1;
        flags_o  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a_i[0]};
      end
      OP_DAA: begin
        result_o = daa_res;
        writes_o = 1'b1;
        flags_o  = '{z: (daa_res == 8'h00), n: flags_i.n, h: 1'b0, c: corr_hi};
      end
      OP_CPL: begin
        result_o = ~a_i;
        writes_o = 1'b1;
        flags_o  = '{z: flags_i.z, n: 1'b1, h: 1'b1, c: flags_i.c};
      end
      OP_SCF: begin
        flags_o = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      OP_CCF: begin
        flags_o = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: ~flags_i.c};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        result_o = sh_res;
        writes_o = 1'b1;
        flags_o  = '{z: (sh_res == 8'h00), n: 1'b0, h: 1'b0, c: sh_c};
      end
      OP_BIT: begin
        result_o = v_i;
        flags_o  = '{z: ((v_i & mask) == 8'h00), n: 1'b0, h: 1'b1, c: flags_i.c};
      end
      OP_RES: begin
        result_o = v_i & ~mask;
        writes_o = 1'b1;
      end
      OP_SET: begin
        result_o = v_i | mask;
        writes_o = 1'b1;
      end
      // unused codes leave everything as it came in
      default: begin
        result_o = a_i;
        writes_o = 1'b0;
        flags_o  = flags_i;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/cpu8_alu_flags.sv @@
// ----------------------------------------------------------------------------
// cpu8_alu_flags
// 8-bit ALU with flag logic: registered operands, one combinational pass,
// registered result and flags.
//
//   channel   handshake           payload
//   command   start / busy        op, acc_value, operand_value, bit_index,
//                                 zero_in, subtract_in, half_carry_in, carry_in
//   result    done (one cycle)    result, writes_result, zero_out,
//                                 subtract_out, half_carry_out, carry_out
//
// one beat accepted per clock; busy stays low
// a result follows its command beat through the operand register,
// then through the datapath into the result register
// reset clears the valid bits of both register stages only
// the result is shown for one cycle and cannot be held off
// ----------------------------------------------------------------------------
`default_nettype none

module cpu8_alu_flags (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [4:0] op_i,
  input  wire logic [7:0] acc_value_i,
  input  wire logic [7:0] operand_value_i,
  input  wire logic [2:0] bit_index_i,
  input  wire logic       zero_in_i,
  input  wire logic       subtract_in_i,
  input  wire logic       half_carry_in_i,
  input  wire logic       carry_in_i,
  output logic            done_o,
  output logic [7:0]      result_o,
  output logic            writes_result_o,
  output logic            zero_out_o,
  output logic            subtract_out_o,
  output logic            half_carry_out_o,
  output logic            carry_out_o
);
  import c8alu_pkg::*;

  logic       accept;
  logic       in_valid_q;
  logic [4:0] op_q;
  logic [7:0] acc_q;
  logic [7:0] opnd_q;
  logic [2:0] bit_idx_q;
  flags_t     flags_in_q;

  logic [7:0] result_d;
  logic       writes_d;
  flags_t     flags_d;

  logic       done_q;
  logic [7:0] result_q;
  logic       writes_q;
  flags_t     flags_out_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= accept;
      done_q     <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= op_i;
      acc_q      <= acc_value_i;
      opnd_q     <= operand_value_i;
      bit_idx_q  <= bit_index_i;
      flags_in_q <= '{z: zero_in_i, n: subtract_in_i, h: half_carry_in_i, c: carry_in_i};
    end
  end

  c8alu_core u_core (
    .op_i        (op_q),
    .a_i         (acc_q),
    .v_i         (opnd_q),
    .bit_index_i (bit_idx_q),
    .flags_i     (flags_in_q),
    .result_o    (result_d),
    .writes_o    (writes_d),
    .flags_o     (flags_d)
  );

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      result_q    <= result_d;
      writes_q    <= writes_d;
      flags_out_q <= flags_d;
    end
  end

  assign done_o           = done_q;
  assign result_o         = result_q;
  assign writes_result_o  = writes_q;
  assign zero_out_o       = flags_out_q.z;
  assign subtract_out_o   = flags_out_q.n;
  assign half_carry_out_o = flags_out_q.h;
  assign carry_out_o      = flags_out_q.c;

endmodule

`default_nettype wire

@@ src/c8alu_checker.sv @@
// ----------------------------------------------------------------------------
// c8alu_checker
// Port-level checks on the ALU: result timing and a few fixed flag outcomes.
// ----------------------------------------------------------------------------
`default_nettype none

module c8alu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [4:0] op_i,
  input wire logic       done_o,
  input wire logic       writes_result_o,
  input wire logic       half_carry_out_o,
  input wire logic       carry_out_o,
  input wire logic       subtract_out_o
);
  import c8alu_pkg::*;

  // every accepted beat gives exactly one result, after both register stages
  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("accepted beat produced no result");

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start, 2) && !$past(busy, 2)))
    else $error("result without an accepted beat");

  a_cp_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(op_i, 2) == OP_CP)) |-> (!writes_result_o && subtract_out_o))
    else $error("compare wrote back or cleared subtract");

  a_and_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(op_i, 2) == OP_AND)) |-> (half_carry_out_o && !carry_out_o))
    else $error("and gave wrong half-carry or carry");

endmodule

bind cpu8_alu_flags c8alu_checker u_checker (.*);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the 8-bit ALU with flag logic. Commands go in as start/busy
// beats. Each result beat is checked against a predictor that runs in the
// bench, field by field and in order. A directed set covers the operations
// and the corner values, and a random set then varies operands and flags.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import c8alu_pkg::*;

  localparam int RandomCmds = 2000;
  localparam int QuietTail  = 300;
  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic [4:0] op;
    logic [7:0] acc;
    logic [7:0] opnd;
    logic [2:0] bidx;
    flags_t     fl;
  } alu_cmd_t;

  typedef struct packed {
    logic [7:0] value;
    logic       wr;
    flags_t     fl;
  } alu_res_t;

  typedef struct packed {
    alu_cmd_t cmd;
    alu_res_t res;
  } pending_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       start           = 1'b0;
  logic [4:0] op_i            = '0;
  logic [7:0] acc_value_i     = '0;
  logic [7:0] operand_value_i = '0;
  logic [2:0] bit_index_i     = '0;
  logic       zero_in_i       = 1'b0;
  logic       subtract_in_i   = 1'b0;
  logic       half_carry_in_i = 1'b0;
  logic       carry_in_i      = 1'b0;
  logic       busy;
  logic       done_o;
  logic [7:0] result_o;
  logic       writes_result_o;
  logic       zero_out_o;
  logic       subtract_out_o;
  logic       half_carry_out_o;
  logic       carry_out_o;

  pending_t   pending_results[$];
  int         fail_cnt    = 0;
  int         cmds_sent   = 0;
  int         results_seen = 0;
  bit [31:0]  ops_hit     = '0;

  cpu8_alu_flags u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .acc_value_i      (acc_value_i),
    .operand_value_i  (operand_value_i),
    .bit_index_i      (bit_index_i),
    .zero_in_i        (zero_in_i),
    .subtract_in_i    (subtract_in_i),
    .half_carry_in_i  (half_carry_in_i),
    .carry_in_i       (carry_in_i),
    .done_o           (done_o),
    .result_o         (result_o),
    .writes_result_o  (writes_result_o),
    .zero_out_o       (zero_out_o),
    .subtract_out_o   (subtract_out_o),
    .half_carry_out_o (half_carry_out_o),
    .carry_out_o      (carry_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic alu_res_t alu_predict(alu_cmd_t cmd);
    alu_res_t   r;
    logic [8:0] sum;
    logic [4:0] nib;
    logic       cc;
    logic [7:0] corr;
    logic [7:0] v;
    logic       cnew;
    // untouched flags pass through; unused codes keep all of this
    r.value = cmd.acc;
    r.wr    = 1'b0;
    r.fl    = cmd.fl;
    cnew    = cmd.fl.c;
    case (cmd.op)
      OP_ADD, OP_ADC: begin
        cc  = (cmd.op == OP_ADC) ? cmd.fl.c : 1'b0;
        sum = {1'b0, cmd.acc} + {1'b0, cmd.opnd} + {8'h00, cc};
        nib = {1'b0, cmd.acc[3:0]} + {1'b0, cmd.opnd[3:0]} + {4'h0, cc};
        r.value = sum[7:0];
        r.wr    = 1'b1;
        r.fl    = {sum[7:0] == 8'h00, 1'b0, nib[4], sum[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // bit 8 / bit 4 go high on a borrow
        cc  = (cmd.op == OP_SBC) ? cmd.fl.c : 1'b0;
        sum = {1'b0, cmd.acc} - {1'b0, cmd.opnd} - {8'h00, cc};
        nib = {1'b0, cmd.acc[3:0]} - {1'b0, cmd.opnd[3:0]} - {4'h0, cc};
        r.value = sum[7:0];
        r.wr    = (cmd.op != OP_CP);
        r.fl    = {sum[7:0] == 8'h00, 1'b1, nib[4], sum[8]};
      end
      OP_AND: begin
        r.value = cmd.acc & cmd.opnd;
        r.wr    = 1'b1;
        r.fl    = {r.value == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR, OP_OR: begin
        r.value = (cmd.op == OP_XOR) ? (cmd.acc ^ cmd.opnd) : (cmd.acc | cmd.opnd);
        r.wr    = 1'b1;
        r.fl    = {r.value == 8'h00, 1'b0, 1'b0, 1'b0};
      end
      OP_INC: begin
        r.value = cmd.opnd + 8'h01;
        r.wr    = 1'b1;
        r.fl    = {r.value == 8'h00, 1'b0, cmd.opnd[3:0] == 4'hf, cmd.fl.c};
      end
      OP_DEC: begin
        r.value = cmd.opnd - 8'h01;
        r.wr    = 1'b1;
        r.fl    = {r.value == 8'h00, 1'b1, cmd.opnd[3:0] == 4'h0, cmd.fl.c};
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        case (cmd.op)
          OP_RLCA: r.value = {cmd.acc[6:0], cmd.acc[7]};
          OP_RRCA: r.value = {cmd.acc[0], cmd.acc[7:1]};
          OP_RLA:  r.value = {cmd.acc[6:0], cmd.fl.c};
          default: r.value = {cmd.fl.c, cmd.acc[7:1]};
        endcase
        cnew = (cmd.op == OP_RLCA || cmd.op == OP_RLA) ? cmd.acc[7] : cmd.acc[0];
        r.wr = 1'b1;
        // zero is cleared even when the rotated value is zero
        r.fl = {1'b0, 1'b0, 1'b0, cnew};
      end
      OP_DAA: begin
        corr = 8'h00;
        if (cmd.fl.h || (!cmd.fl.n && cmd.acc[3:0] > DaaLoLimit)) begin
          corr[3:0] = 4'h6;
        end
        if (cmd.fl.c || (!cmd.fl.n && cmd.acc > DaaHiLimit)) begin
          corr[7:4] = 4'h6;
          cnew      = 1'b1;
        end
        r.value = cmd.fl.n ? (cmd.acc - corr) : (cmd.acc + corr);
        r.wr    = 1'b1;
        r.fl    = {r.value == 8'h00, cmd.fl.n, 1'b0, cnew};
      end
      OP_CPL: begin
        r.value = ~cmd.acc;
        r.wr    = 1'b1;
        r.fl    = {cmd.fl.z, 1'b1, 1'b1, cmd.fl.c};
      end
      OP_SCF: r.fl = {cmd.fl.z, 1'b0, 1'b0, 1'b1};
      OP_CCF: r.fl = {cmd.fl.z, 1'b0, 1'b0, ~cmd.fl.c};
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        case (cmd.op)
          OP_RLC:  v = {cmd.opnd[6:0], cmd.opnd[7]};
          OP_RRC:  v = {cmd.opnd[0], cmd.opnd[7:1]};
          OP_RL:   v = {cmd.opnd[6:0], cmd.fl.c};
          OP_RR:   v = {cmd.fl.c, cmd.opnd[7:1]};
          OP_SLA:  v = {cmd.opnd[6:0], 1'b0};
          OP_SRA:  v = {cmd.opnd[7], cmd.opnd[7:1]};
          OP_SWAP: v = {cmd.opnd[3:0], cmd.opnd[7:4]};
          default: v = {1'b0, cmd.opnd[7:1]};
        endcase
        case (cmd.op)
          OP_RLC, OP_RL, OP_SLA: cnew = cmd.opnd[7];
          OP_SWAP:               cnew = 1'b0;
          default:               cnew = cmd.opnd[0];
        endcase
        r.value = v;
        r.wr    = 1'b1;
        r.fl    = {v == 8'h00, 1'b0, 1'b0, cnew};
      end
      OP_BIT: begin
        r.value = cmd.opnd;
        r.fl    = {~cmd.opnd[cmd.bidx], 1'b0, 1'b1, cmd.fl.c};
      end
      OP_RES: begin
        r.value = cmd.opnd & ~(8'h01 << cmd.bidx);
        r.wr    = 1'b1;
      end
      OP_SET: begin
        r.value = cmd.opnd | (8'h01 << cmd.bidx);
        r.wr    = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic alu_cmd_t mk_cmd(logic [4:0] op, logic [7:0] acc, logic [7:0] opnd,
                                      logic [2:0] bidx, logic [3:0] fl);
    alu_cmd_t c;
    c.op   = op;
    c.acc  = acc;
    c.opnd = opnd;
    c.bidx = bidx;
    c.fl   = fl;
    return c;
  endfunction

  task automatic report_fail(string msg);
    $display("FAIL @%0t: %s", $realtime, msg);
    fail_cnt++;
  endtask

  // drive one command beat and log its prediction once it is taken
  task automatic send_cmd(alu_cmd_t cmd);
    @(negedge clk_i);
    start           <= 1'b1;
    op_i            <= cmd.op;
    acc_value_i     <= cmd.acc;
    operand_value_i <= cmd.opnd;
    bit_index_i     <= cmd.bidx;
    {zero_in_i, subtract_in_i, half_carry_in_i, carry_in_i} <= cmd.fl;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.push_back('{cmd: cmd, res: alu_predict(cmd)});
    ops_hit[cmd.op] = 1'b1;
    cmds_sent++;
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // result checker: one beat per done strobe, compared in order
  always @(posedge clk_i) begin
    pending_t exp;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_fail($sformatf("result beat with nothing outstanding, result %02h", result_o));
      end else begin
        exp = pending_results.pop_front();
        results_seen++;
        if (result_o !== exp.res.value)
          report_fail($sformatf("op %0d result got %02h want %02h",
                                exp.cmd.op, result_o, exp.res.value));
        if (writes_result_o !== exp.res.wr)
          report_fail($sformatf("op %0d writes_result got %b want %b",
                                exp.cmd.op, writes_result_o, exp.res.wr));
        if (zero_out_o !== exp.res.fl.z)
          report_fail($sformatf("op %0d zero got %b want %b",
                                exp.cmd.op, zero_out_o, exp.res.fl.z));
        if (subtract_out_o !== exp.res.fl.n)
          report_fail($sformatf("op %0d subtract got %b want %b",
                                exp.cmd.op, subtract_out_o, exp.res.fl.n));
        if (half_carry_out_o !== exp.res.fl.h)
          report_fail($sformatf("op %0d half-carry got %b want %b",
                                exp.cmd.op, half_carry_out_o, exp.res.fl.h));
        if (carry_out_o !== exp.res.fl.c)
          report_fail($sformatf("op %0d carry got %b want %b",
                                exp.cmd.op, carry_out_o, exp.res.fl.c));
      end
    end
  end

  task automatic test_arith_edges();
    send_cmd(mk_cmd(OP_ADD, 8'hff, 8'h01, 3'd0, 4'b0000));
    send_cmd(mk_cmd(OP_ADC, 8'h0f, 8'h00, 3'd0, 4'b0001));
    send_cmd(mk_cmd(OP_SUB, 8'h00, 8'h01, 3'd0, 4'b1110));
    send_cmd(mk_cmd(OP_SBC, 8'h10, 8'h0f, 3'd0, 4'b0001));
    // compare: difference on the result lines, nothing written
    send_cmd(mk_cmd(OP_CP,  8'h3c, 8'h3c, 3'd0, 4'b0000));
  endtask

  task automatic test_logic_ops();
    send_cmd(mk_cmd(OP_AND, 8'h00, 8'hff, 3'd0, 4'b1111));
    send_cmd(mk_cmd(OP_XOR, 8'hff, 8'hff, 3'd0, 4'b0000));
    send_cmd(mk_cmd(OP_OR,  8'h80, 8'h00, 3'd0, 4'b1111));
  endtask

  task automatic test_inc_dec();
    send_cmd(mk_cmd(OP_INC, 8'h00, 8'hff, 3'd0, 4'b0101));
    send_cmd(mk_cmd(OP_DEC, 8'hff, 8'h00, 3'd0, 4'b1010));
    send_cmd(mk_cmd(OP_DEC, 8'h00, 8'h01, 3'd0, 4'b0000));
  endtask

  task automatic test_acc_rotates();
    send_cmd(mk_cmd(OP_RLCA, 8'h80, 8'h00, 3'd0, 4'b1000));
    send_cmd(mk_cmd(OP_RRCA, 8'h01, 8'h00, 3'd0, 4'b1110));
    send_cmd(mk_cmd(OP_RLA,  8'h00, 8'h00, 3'd0, 4'b1000));
    send_cmd(mk_cmd(OP_RRA,  8'h01, 8'h00, 3'd0, 4'b0001));
  endtask

  task automatic test_decimal_adjust();
    send_cmd(mk_cmd(OP_DAA, 8'h9a, 8'h00, 3'd0, 4'b0000));
    send_cmd(mk_cmd(OP_DAA, 8'hff, 8'h00, 3'd0, 4'b0111));
    send_cmd(mk_cmd(OP_DAA, 8'h00, 8'h00, 3'd0, 4'b1000));
  endtask

  task automatic test_flag_ops();
    send_cmd(mk_cmd(OP_CPL, 8'h55, 8'h00, 3'd0, 4'b1000));
    send_cmd(mk_cmd(OP_SCF, 8'ha5, 8'h00, 3'd0, 4'b0110));
    send_cmd(mk_cmd(OP_CCF, 8'h5a, 8'h00, 3'd0, 4'b1111));
  endtask

  task automatic test_prefixed_shifts();
    send_cmd(mk_cmd(OP_RLC,  8'h00, 8'h80, 3'd0, 4'b0000));
    send_cmd(mk_cmd(OP_RRC,  8'h00, 8'h01, 3'd0, 4'b1111));
    send_cmd(mk_cmd(OP_RL,   8'h00, 8'h80, 3'd0, 4'b0000));
    send_cmd(mk_cmd(OP_RR,   8'h00, 8'h00, 3'd0, 4'b0001));
    send_cmd(mk_cmd(OP_SLA,  8'h00, 8'hff, 3'd0, 4'b0000));
    send_cmd(mk_cmd(OP_SRA,  8'h00, 8'h81, 3'd0, 4'b0000));
    send_cmd(mk_cmd(OP_SWAP, 8'h00, 8'hf0, 3'd0, 4'b0001));
    send_cmd(mk_cmd(OP_SRL,  8'h00, 8'h01, 3'd0, 4'b0000));
  endtask

  task automatic test_bit_ops();
    send_cmd(mk_cmd(OP_BIT, 8'h00, 8'h7f, 3'd7, 4'b0001));
    send_cmd(mk_cmd(OP_RES, 8'h00, 8'hff, 3'd0, 4'b1010));
    send_cmd(mk_cmd(OP_SET, 8'h00, 8'h00, 3'd7, 4'b0101));
  endtask

  task automatic test_unused_codes();
    send_cmd(mk_cmd(5'd31, 8'hc3, 8'hff, 3'd7, 4'b1010));
    send_cmd(mk_cmd(5'd29, 8'h3c, 8'h00, 3'd0, 4'b0101));
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] corner[8] = '{8'h00, 8'hff, 8'h0f, 8'hf0, 8'h99, 8'h9a, 8'h80, 8'h01};
    // bias towards nibble and decimal boundaries now and then
    if ($urandom_range(0, 5) == 0) return corner[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  task automatic test_random_mix();
    alu_cmd_t c;
    for (int i = 0; i < RandomCmds; i++) begin
      c.op   = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(29, 31))
                                             : 5'($urandom_range(0, 28));
      c.acc  = pick_byte();
      c.opnd = pick_byte();
      c.bidx = 3'($urandom_range(0, 7));
      c.fl   = 4'($urandom_range(0, 15));
      send_cmd(c);
      // bursts of idle beats, none in the closing stretch
      if (i < RandomCmds - QuietTail && $urandom_range(0, 5) == 0)
        idle_cycles($urandom_range(1, 12));
    end
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    idle_cycles(3);

    test_arith_edges();
    test_logic_ops();
    idle_cycles(2);
    test_inc_dec();
    test_acc_rotates();
    test_decimal_adjust();
    idle_cycles(5);
    test_flag_ops();
    test_prefixed_shifts();
    test_bit_ops();
    test_unused_codes();
    test_random_mix();

    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk_i);
    // two-stage pipe, plus a margin for any stray beat
    repeat (6) @(posedge clk_i);

    $display("tb_top: %0d commands issued, %0d result beats compared",
             cmds_sent, results_seen);
    $display("tb_top: %0d of 32 op codes exercised, unused codes included",
             $countones(ops_hit));
    if (fail_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/c8alu_pkg.sv
src/c8alu_core.sv
src/cpu8_alu_flags.sv
src/c8alu_checker.sv
tb/sv/tb_top.sv
